FILE: sv/lfr_pkg.sv
// Package: sizes, entry layout, scan summary and sequencer states for the LFU replacement unit
`timescale 1ns / 1ps
package lfr_pkg;

	localparam int FRAMES    = 16;
	localparam int KEY_WIDTH = 8;
	localparam int CNT_W     = 16;
	localparam int STAMP_W   = 32;
	localparam int LIMIT_W   = 5;
	localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int USED_W    = $clog2(FRAMES + 1);
	localparam int CMP_W     = (USED_W > LIMIT_W) ? USED_W : LIMIT_W;

	localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(FRAMES - 1);
	localparam logic [CMP_W-1:0]   FRAMES_CMP = CMP_W'(FRAMES);
	localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(16);

	typedef struct packed {
		logic [KEY_WIDTH-1:0] key;
		logic [CNT_W-1:0]     count;
		logic [STAMP_W-1:0]   stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                 match_found;
		logic [IDX_W-1:0]     match_idx;
		logic [CNT_W-1:0]     match_count;
		logic [STAMP_W-1:0]   match_stamp;
		logic                 victim_found;
		logic [IDX_W-1:0]     victim_idx;
		logic [KEY_WIDTH-1:0] victim_key;
		logic [CNT_W-1:0]     victim_count;
		logic [STAMP_W-1:0]   victim_stamp;
		logic                 free_found;
		logic [IDX_W-1:0]     free_idx;
		logic [USED_W-1:0]    used;
	} scan_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

FILE: sv/lfr_replacement_unit_top.sv
// Top level: sequencer, valid bits, stamp counter and result register
`timescale 1ns / 1ps
// LFU frame replacement unit.
// Input channel (in_valid/in_ready, ref_key): one beat is one key reference.
// Output channel (out_valid/out_ready): one result beat per reference with
// hit, evicted, evicted_key and new_count.
// Config channel (cfg_valid/cfg_ready, cfg_data): writes frames_in_use; it
// is always ready and should only be written while the unit is idle.
// Each reference reads all FRAMES entries of the entry RAM, one per cycle,
// to find a match, the eviction victim and the first free slot; a drain
// step then covers the RAM read latency and a finish step writes the entry
// back and loads the result. A new reference is taken only once the last
// one has been written back; the sequential pass over the single RAM read
// port sets this.
// in_ready is high only when no reference is in progress.
// If the receiver stalls with a result pending, the next reference still
// runs its scan and then waits in the write-back step until the output
// register frees up.
// Reset clears all valid bits, the stamp counter and the output valid flag,
// and sets frames_in_use to 16; the RAM itself is not cleared.
module lfu_frame_replacement_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lfr_pkg::KEY_WIDTH-1:0] ref_key,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic                          evicted,
	output logic [7:0]                    evicted_key,
	output logic [15:0]                   new_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lfr_pkg::LIMIT_W-1:0]   cfg_data
);

	lfr_pkg::state_t state_q, state_d;

	logic [lfr_pkg::LIMIT_W-1:0]   limit_q;
	logic [lfr_pkg::KEY_WIDTH-1:0] key_q;
	logic [lfr_pkg::STAMP_W-1:0]   time_q;
	logic [lfr_pkg::FRAMES-1:0]    valid_q;
	logic [lfr_pkg::IDX_W-1:0]     rd_addr_q;
	logic                          eval_s1;
	logic [lfr_pkg::IDX_W-1:0]     idx_s1;

	logic                          out_valid_q;
	logic                          hit_q;
	logic                          evicted_q;
	logic [7:0]                    evicted_key_q;
	logic [15:0]                   new_count_q;

	logic                          accept;
	logic                          rd_en;
	logic                          fin_go;
	logic                          idle;

	lfr_pkg::entry_t               rd_entry;
	lfr_pkg::entry_t               wr_entry;
	logic [lfr_pkg::ENTRY_W-1:0]   rd_word;
	logic [lfr_pkg::IDX_W-1:0]     slot;
	lfr_pkg::scan_res_t            res;

	logic [lfr_pkg::CMP_W-1:0]     limit_ext;
	logic [lfr_pkg::CMP_W-1:0]     limit_eff;
	logic [lfr_pkg::CMP_W-1:0]     used_ext;
	logic                          do_evict;
	logic [lfr_pkg::CNT_W-1:0]     count_new;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lfr_pkg::ST_IDLE: begin
				if (in_valid) state_d = lfr_pkg::ST_SCAN;
			end
			lfr_pkg::ST_SCAN: begin
				if (rd_addr_q == lfr_pkg::LAST_IDX) state_d = lfr_pkg::ST_DRAIN;
			end
			lfr_pkg::ST_DRAIN: begin
				state_d = lfr_pkg::ST_FINISH;
			end
			lfr_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) state_d = lfr_pkg::ST_IDLE;
			end
			default: begin
				state_d = lfr_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		idle   = 1'b0;
		rd_en  = 1'b0;
		fin_go = 1'b0;
		case (state_q)
			lfr_pkg::ST_IDLE:   idle   = 1'b1;
			lfr_pkg::ST_SCAN:   rd_en  = 1'b1;
			lfr_pkg::ST_DRAIN:  idle   = 1'b0;
			lfr_pkg::ST_FINISH: fin_go = !out_valid_q || out_ready;
			default:            idle   = 1'b0;
		endcase
	end

	assign in_ready  = idle;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lfr_pkg::LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= ref_key;
		end
	end

	// read address sweep and read-data alignment registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			eval_s1   <= 1'b0;
			idx_s1    <= '0;
		end else begin
			eval_s1 <= rd_en;
			idx_s1  <= rd_addr_q;
			if (accept) begin
				rd_addr_q <= '0;
			end else if (rd_en) begin
				rd_addr_q <= rd_addr_q + lfr_pkg::IDX_W'(1);
			end
		end
	end

	lfr_entry_ram #(
		.WIDTH  (lfr_pkg::ENTRY_W),
		.DEPTH  (lfr_pkg::FRAMES),
		.ADDR_W (lfr_pkg::IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (fin_go),
		.wr_addr (slot),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_q),
		.rd_data (rd_word)
	);

	assign rd_entry = lfr_pkg::entry_t'(rd_word);

	lfr_scan_unit u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (accept),
		.eval      (eval_s1),
		.idx       (idx_s1),
		.ent_valid (valid_q[idx_s1]),
		.entry     (rd_entry),
		.key       (key_q),
		.res       (res)
	);

	// write-back decision
	always_comb begin
		limit_ext = lfr_pkg::CMP_W'(limit_q);
		if (limit_q == '0) begin
			limit_eff = lfr_pkg::CMP_W'(1);
		end else if (limit_ext > lfr_pkg::FRAMES_CMP) begin
			limit_eff = lfr_pkg::FRAMES_CMP;
		end else begin
			limit_eff = limit_ext;
		end
		used_ext = lfr_pkg::CMP_W'(res.used);
		do_evict = !res.match_found && ((used_ext >= limit_eff) || !res.free_found);

		if (res.match_count == '1) begin
			count_new = res.match_count;
		end else begin
			count_new = res.match_count + lfr_pkg::CNT_W'(1);
		end

		wr_entry.key = key_q;
		if (res.match_found) begin
			slot           = res.match_idx;
			wr_entry.count = count_new;
			wr_entry.stamp = res.match_stamp;
		end else begin
			slot           = do_evict ? res.victim_idx : res.free_idx;
			wr_entry.count = lfr_pkg::CNT_W'(1);
			wr_entry.stamp = time_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			time_q  <= '0;
		end else if (fin_go) begin
			valid_q[slot] <= 1'b1;
			if (time_q != '1) begin
				time_q <= time_q + lfr_pkg::STAMP_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			hit_q         <= res.match_found;
			evicted_q     <= do_evict;
			evicted_key_q <= do_evict ? res.victim_key : '0;
			new_count_q   <= wr_entry.count;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;
	assign new_count   = new_count_q;

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == lfr_pkg::ST_SCAN && rd_addr_q == '0))
		else $error("accepted beat did not start a scan from entry zero");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && res.match_found) |-> !do_evict)
		else $error("hit flagged together with an eviction");

	a_evict_has_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && do_evict) |-> res.victim_found)
		else $error("eviction without a valid victim");

	a_stamp_advances: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (time_q == $past(time_q) + lfr_pkg::STAMP_W'(1) || $past(time_q) == '1))
		else $error("stamp counter did not advance on write-back");

endmodule

FILE: sv/lfr_entry_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data
`timescale 1ns / 1ps
module lfr_entry_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/lfr_scan_unit.sv
// Scan unit: folds one table entry per cycle while eval is high into match, victim, free slot and occupancy
`timescale 1ns / 1ps
module lfr_scan_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         clear,
	input  logic                         eval,
	input  logic [lfr_pkg::IDX_W-1:0]    idx,
	input  logic                         ent_valid,
	input  lfr_pkg::entry_t              entry,
	input  logic [lfr_pkg::KEY_WIDTH-1:0] key,
	output lfr_pkg::scan_res_t           res
);

	lfr_pkg::scan_res_t res_q;
	lfr_pkg::scan_res_t res_d;
	logic               worse;

	// eviction order: lower count, then older stamp, then lower key
	always_comb begin
		if (entry.count != res_q.victim_count) begin
			worse = entry.count < res_q.victim_count;
		end else if (entry.stamp != res_q.victim_stamp) begin
			worse = entry.stamp < res_q.victim_stamp;
		end else begin
			worse = entry.key < res_q.victim_key;
		end
	end

	always_comb begin
		res_d = res_q;
		if (ent_valid) begin
			res_d.used = res_q.used + lfr_pkg::USED_W'(1);
			if (entry.key == key) begin
				res_d.match_found = 1'b1;
				res_d.match_idx   = idx;
				res_d.match_count = entry.count;
				res_d.match_stamp = entry.stamp;
			end
			if (!res_q.victim_found || worse) begin
				res_d.victim_found = 1'b1;
				res_d.victim_idx   = idx;
				res_d.victim_key   = entry.key;
				res_d.victim_count = entry.count;
				res_d.victim_stamp = entry.stamp;
			end
		end else if (!res_q.free_found) begin
			res_d.free_found = 1'b1;
			res_d.free_idx   = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (clear) begin
			res_q <= '0;
		end else if (eval) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.used <= lfr_pkg::USED_W'(lfr_pkg::FRAMES))
		else $error("occupancy count exceeds table size");

	a_victim_when_used: assert property (@(posedge clk) disable iff (!arst_n)
		(res_q.used != '0) |-> res_q.victim_found)
		else $error("valid entries seen but no victim tracked");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (!res_q.match_found && !res_q.free_found && res_q.used == '0))
		else $error("scan summary not cleared");

endmodule

FILE: test/lfu_frame_replacement_checker.sv
// Checker for the LFU frame replacement unit: predicts each lookup and compares result beats
`timescale 1ns / 1ps
module lfu_frame_replacement_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [lfr_pkg::KEY_WIDTH-1:0] ref_key,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          hit,
	input  logic                          evicted,
	input  logic [7:0]                    evicted_key,
	input  logic [15:0]                   new_count,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [lfr_pkg::LIMIT_W-1:0]   cfg_data,
	output int                            fail_count,
	output int                            outstanding,
	output int                            hit_total,
	output int                            evict_total
);

	typedef struct packed {
		logic        hit;
		logic        evicted;
		logic [7:0]  evicted_key;
		logic [15:0] new_count;
	} frame_result_t;

	logic                          frame_held  [lfr_pkg::FRAMES];
	logic [lfr_pkg::KEY_WIDTH-1:0] frame_key   [lfr_pkg::FRAMES];
	logic [lfr_pkg::CNT_W-1:0]     frame_uses  [lfr_pkg::FRAMES];
	logic [lfr_pkg::STAMP_W-1:0]   frame_stamp [lfr_pkg::FRAMES];
	logic [lfr_pkg::STAMP_W-1:0]   ref_clock;
	logic [lfr_pkg::LIMIT_W-1:0]   frame_limit;
	frame_result_t                 expected_results[$];

	function automatic logic evicts_first(int a, int b);
		if (frame_uses[a] != frame_uses[b])
			return frame_uses[a] < frame_uses[b];
		if (frame_stamp[a] != frame_stamp[b])
			return frame_stamp[a] < frame_stamp[b];
		return frame_key[a] < frame_key[b];
	endfunction

	function automatic frame_result_t reference_key(logic [lfr_pkg::KEY_WIDTH-1:0] key);
		int match_idx = -1;
		int free_idx = -1;
		int victim_idx = -1;
		int slot;
		int used = 0;
		int limit;
		frame_result_t r;
		r = '0;
		for (int i = 0; i < lfr_pkg::FRAMES; i++) begin
			if (frame_held[i]) begin
				used++;
				if (frame_key[i] == key)
					match_idx = i;
				if (victim_idx < 0 || evicts_first(i, victim_idx))
					victim_idx = i;
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		limit = (frame_limit == 0) ? 1 :
			(frame_limit > lfr_pkg::FRAMES) ? lfr_pkg::FRAMES : int'(frame_limit);
		if (match_idx >= 0) begin
			r.hit = 1'b1;
			slot = match_idx;
			if (frame_uses[slot] != '1)
				frame_uses[slot]++;
		end else begin
			if (used >= limit || free_idx < 0) begin
				slot = victim_idx;
				r.evicted = 1'b1;
				r.evicted_key = 8'(frame_key[slot]);
			end else begin
				slot = free_idx;
			end
			frame_held[slot]  = 1'b1;
			frame_key[slot]   = key;
			frame_uses[slot]  = 1;
			frame_stamp[slot] = ref_clock;
		end
		if (ref_clock != '1)
			ref_clock++;
		r.new_count = 16'(frame_uses[slot]);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		int            errs;
		if (!arst_n) begin
			for (int i = 0; i < lfr_pkg::FRAMES; i++)
				frame_held[i] = 1'b0;
			ref_clock   = '0;
			frame_limit = lfr_pkg::LIMIT_RST;
			expected_results.delete();
			fail_count  <= 0;
			outstanding <= 0;
			hit_total   <= 0;
			evict_total <= 0;
		end else begin
			errs = 0;
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no reference pending");
					errs++;
				end else begin
					want = expected_results.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0d, actual %0d", want.hit, hit);
						errs++;
					end
					if (evicted !== want.evicted) begin
						$error("evicted: expected %0d, actual %0d", want.evicted, evicted);
						errs++;
					end
					if (evicted_key !== want.evicted_key) begin
						$error("evicted_key: expected 0x%02h, actual 0x%02h",
							want.evicted_key, evicted_key);
						errs++;
					end
					if (new_count !== want.new_count) begin
						$error("new_count: expected %0d, actual %0d", want.new_count, new_count);
						errs++;
					end
					hit_total   <= hit_total + int'(want.hit);
					evict_total <= evict_total + int'(want.evicted);
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
			if (cfg_valid && cfg_ready)
				frame_limit = cfg_data;
			if (in_valid && in_ready)
				expected_results.push_back(reference_key(ref_key));
			outstanding <= expected_results.size();
		end
	end

endmodule

FILE: test/tb_lfu_frame_replacement_unit.sv
// Testbench top for the LFU frame replacement unit: stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module tb_lfu_frame_replacement_unit;

	localparam int PHASES     = 10;
	localparam int PHASE_REFS = 90;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [lfr_pkg::KEY_WIDTH-1:0] ref_key;
	logic                          out_valid;
	logic                          out_ready;
	logic                          hit;
	logic                          evicted;
	logic [7:0]                    evicted_key;
	logic [15:0]                   new_count;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [lfr_pkg::LIMIT_W-1:0]   cfg_data;

	int fail_count;
	int outstanding;
	int hit_total;
	int evict_total;
	int refs_sent;
	int limits_written;
	bit quiet;

	lfu_frame_replacement_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ref_key     (ref_key),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.evicted     (evicted),
		.evicted_key (evicted_key),
		.new_count   (new_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	lfu_frame_replacement_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ref_key     (ref_key),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.evicted     (evicted),
		.evicted_key (evicted_key),
		.new_count   (new_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.hit_total   (hit_total),
		.evict_total (evict_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// valid stays high across back-to-back beats
	task automatic send_ref(input logic [lfr_pkg::KEY_WIDTH-1:0] key);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		ref_key  <= key;
		do @(posedge clk); while (!in_ready);
		refs_sent++;
	endtask

	task automatic write_limit(input logic [lfr_pkg::LIMIT_W-1:0] value);
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limits_written++;
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		logic [lfr_pkg::KEY_WIDTH-1:0] fill_keys[];
		logic [lfr_pkg::KEY_WIDTH-1:0] after_shrink[];
		logic [lfr_pkg::LIMIT_W-1:0]   phase_limits[PHASES-1];
		logic [lfr_pkg::LIMIT_W-1:0]   limit;
		logic [lfr_pkg::KEY_WIDTH-1:0] pool_base;
		int                            pool_size;
		logic [lfr_pkg::KEY_WIDTH-1:0] key;
		in_valid  = 1'b0;
		ref_key   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		quiet     = 1'b0;
		refs_sent = 0;
		limits_written = 0;
		fill_keys = '{8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'hFF,
			8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
			8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C,
			8'hC8, 8'h0D};
		after_shrink = '{8'h80, 8'h80, 8'h7F};
		phase_limits = '{5'd0, 5'd31, 5'd17, 5'd4, 5'd2, 5'd16, 5'd8, 5'd15, 5'd1};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill all frames at the reset limit, then two evictions
		foreach (fill_keys[i])
			send_ref(fill_keys[i]);
		// limit drops far below occupancy
		write_limit(5'd1);
		foreach (after_shrink[i])
			send_ref(after_shrink[i]);

		for (int p = 0; p < PHASES; p++) begin
			limit = (p == PHASES - 1) ? lfr_pkg::LIMIT_W'($urandom_range(0, 31)) :
				phase_limits[p];
			quiet = (p % 4 == 3);
			write_limit(limit);
			pool_base = lfr_pkg::KEY_WIDTH'($urandom_range(0, 255));
			pool_size = $urandom_range(2, 24);
			for (int n = 0; n < PHASE_REFS; n++) begin
				if ($urandom_range(0, 9) < 7)
					key = pool_base + lfr_pkg::KEY_WIDTH'($urandom_range(0, pool_size - 1));
				else
					key = lfr_pkg::KEY_WIDTH'($urandom_range(0, 255));
				send_ref(key);
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (lfr_pkg::FRAMES + 8) @(posedge clk);
		$display("Sent %0d key references under %0d frame limits,", refs_sent, limits_written);
		$display("edge values 0, 1, 16, 17, 31 among them; results checked: %0d hits, %0d evictions",
			hit_total, evict_total);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
sv/lfr_pkg.sv
sv/lfr_entry_ram.sv
sv/lfr_scan_unit.sv
sv/lfr_replacement_unit_top.sv
test/lfu_frame_replacement_checker.sv
test/tb_lfu_frame_replacement_unit.sv
